[rtl/dcct_pkg.sv]
// Shared constants, face tables and pipeline item type for the cube cross texel lookup.
package dcct_pkg;

  // Default configuration of the block
  localparam int MAX_TILE_DEF        = 1024;
  localparam int COORD_FRAC_BITS_DEF = 15;

  // Field widths fixed by the interface
  localparam int DIR_W        = 16;
  localparam int TILE_CFG_W   = 11;
  localparam int TILE_RESET   = 256;
  localparam int FACE_W       = 3;
  localparam int OUT_COORD_W  = 12;
  localparam int OUT_ADDR_W   = 24;
  localparam int NUM_FACES    = 6;
  localparam int BASE_W       = 3;

  typedef logic [1:0]        axis_t;
  typedef logic [BASE_W-1:0] base_t;

  // Major axis, column minor axis and row minor axis of each face (0 = x, 1 = y, 2 = z)
  localparam axis_t MAJOR_AX [NUM_FACES] = '{2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd2};
  localparam axis_t COL_AX   [NUM_FACES] = '{2'd0, 2'd2, 2'd0, 2'd0, 2'd2, 2'd0};
  localparam axis_t ROW_AX   [NUM_FACES] = '{2'd2, 2'd1, 2'd1, 2'd2, 2'd1, 2'd1};

  // Bit i set: face i looks down the negative major axis
  localparam logic [NUM_FACES-1:0] FACE_NEG = 6'b111000;
  // Bit i set: the minor term enters the column or row position negated
  localparam logic [NUM_FACES-1:0] COL_NEG  = 6'b010000;
  localparam logic [NUM_FACES-1:0] ROW_NEG  = 6'b001100;

  // Tile offset in half tiles, less one (the minor term is pre-biased by one major)
  localparam base_t COL_BASE [NUM_FACES] = '{3'd2, 3'd4, 3'd2, 3'd2, 3'd0, 3'd2};
  localparam base_t ROW_BASE [NUM_FACES] = '{3'd4, 3'd2, 3'd6, 3'd0, 3'd2, 3'd2};

  // Per-transaction control carried alongside the divider data
  typedef struct packed {
    logic              hit;
    logic [FACE_W-1:0] face;
    base_t             col_base;
    base_t             row_base;
    logic [DIR_W-1:0]  major;
  } item_t;

endpackage

[rtl/dcct_face_sel.sv]
// Face selection, minor term biasing and integer quotient digits (three register stages).
module dcct_face_sel #(
  parameter int QW = dcct_pkg::COORD_FRAC_BITS_DEF + 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [dcct_pkg::DIR_W-1:0]   dir_x,
  input  logic signed [dcct_pkg::DIR_W-1:0]   dir_y,
  input  logic signed [dcct_pkg::DIR_W-1:0]   dir_z,
  output logic                                valid_out,
  output dcct_pkg::item_t                     item_out,
  output logic [dcct_pkg::DIR_W-1:0]          rem_col,
  output logic [dcct_pkg::DIR_W-1:0]          rem_row,
  output logic [QW-1:0]                       quo_col,
  output logic [QW-1:0]                       quo_row
);
  import dcct_pkg::*;

  localparam int SW = DIR_W + 1;

  logic signed [SW-1:0]  comp  [3];
  logic signed [SW-1:0]  mag   [3];
  logic signed [SW-1:0]  maj_f [NUM_FACES];
  logic [NUM_FACES-1:0]  match;
  logic [FACE_W-1:0]     sel;
  logic signed [SW-1:0]  tcol_next;
  logic signed [SW-1:0]  trow_next;

  logic                  v1;
  item_t                 item1;
  logic signed [SW-1:0]  tcol1;
  logic signed [SW-1:0]  trow1;

  logic signed [SW:0]    sum_col;
  logic signed [SW:0]    sum_row;
  logic                  v2;
  item_t                 item2;
  logic [SW-1:0]         tp_col2;
  logic [SW-1:0]         tp_row2;

  logic [SW-1:0]         m1;
  logic [SW-1:0]         m2;
  logic [1:0]            qi_col;
  logic [1:0]            qi_row;
  logic [SW-1:0]         rc_full;
  logic [SW-1:0]         rr_full;

  // Widen components and take magnitudes
  always_comb begin
    comp[0] = SW'(dir_x);
    comp[1] = SW'(dir_y);
    comp[2] = SW'(dir_z);
    for (int k = 0; k < 3; k++) begin
      mag[k] = (comp[k] < 0) ? -comp[k] : comp[k];
    end
  end

  // Test every face; the highest matching index wins
  always_comb begin
    for (int i = 0; i < NUM_FACES; i++) begin
      maj_f[i] = FACE_NEG[i] ? -comp[MAJOR_AX[i]] : comp[MAJOR_AX[i]];
      match[i] = (maj_f[i] > 0) && (maj_f[i] >= mag[COL_AX[i]]) &&
                 (maj_f[i] >= mag[ROW_AX[i]]);
    end
    sel = '0;
    for (int i = 0; i < NUM_FACES; i++) begin
      if (match[i]) sel = FACE_W'(i);
    end
    tcol_next = COL_NEG[sel] ? -comp[COL_AX[sel]] : comp[COL_AX[sel]];
    trow_next = ROW_NEG[sel] ? -comp[ROW_AX[sel]] : comp[ROW_AX[sel]];
  end

  // Stage 1: register the selected face and its signed minor terms
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    item1.hit      <= |match;
    item1.face     <= sel;
    item1.col_base <= COL_BASE[sel];
    item1.row_base <= ROW_BASE[sel];
    item1.major    <= maj_f[sel][DIR_W-1:0];
    tcol1          <= tcol_next;
    trow1          <= trow_next;
  end

  // Stage 2: bias minor terms by one major so they are never negative
  assign sum_col = (SW+1)'(tcol1) + (SW+1)'(signed'({1'b0, item1.major}));
  assign sum_row = (SW+1)'(trow1) + (SW+1)'(signed'({1'b0, item1.major}));

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    item2   <= item1;
    tp_col2 <= sum_col[SW-1:0];
    tp_row2 <= sum_row[SW-1:0];
  end

  // Stage 3: integer quotient digit (0 to 2) and first remainder
  always_comb begin
    m1 = {1'b0, item2.major};
    m2 = {item2.major, 1'b0};
    if (tp_col2 >= m2) begin
      qi_col  = 2'd2;
      rc_full = tp_col2 - m2;
    end else if (tp_col2 >= m1) begin
      qi_col  = 2'd1;
      rc_full = tp_col2 - m1;
    end else begin
      qi_col  = 2'd0;
      rc_full = tp_col2;
    end
    if (tp_row2 >= m2) begin
      qi_row  = 2'd2;
      rr_full = tp_row2 - m2;
    end else if (tp_row2 >= m1) begin
      qi_row  = 2'd1;
      rr_full = tp_row2 - m1;
    end else begin
      qi_row  = 2'd0;
      rr_full = tp_row2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= v2;
    end
    item_out <= item2;
    rem_col  <= rc_full[DIR_W-1:0];
    rem_row  <= rr_full[DIR_W-1:0];
    quo_col  <= QW'(qi_col);
    quo_row  <= QW'(qi_row);
  end

  // Only the zero vector misses every face
  a_miss_only_zero: assert property (@(posedge clk) disable iff (rst)
    v1 && !item1.hit |-> $past(dir_x == '0 && dir_y == '0 && dir_z == '0))
    else $error("face miss on a non-zero direction");

  // A selected face always has a strictly positive major component
  a_major_nonzero: assert property (@(posedge clk) disable iff (rst)
    v1 && item1.hit |-> item1.major != '0)
    else $error("selected face with zero major component");

endmodule

[rtl/dcct_div_step.sv]
// One restoring divider step: one fractional quotient bit for column and row.
module dcct_div_step #(
  parameter int QW = dcct_pkg::COORD_FRAC_BITS_DEF + 2
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        valid_in,
  input  dcct_pkg::item_t             item_in,
  input  logic [dcct_pkg::DIR_W-1:0]  rem_col_in,
  input  logic [dcct_pkg::DIR_W-1:0]  rem_row_in,
  input  logic [QW-1:0]               quo_col_in,
  input  logic [QW-1:0]               quo_row_in,
  output logic                        valid_out,
  output dcct_pkg::item_t             item_out,
  output logic [dcct_pkg::DIR_W-1:0]  rem_col_out,
  output logic [dcct_pkg::DIR_W-1:0]  rem_row_out,
  output logic [QW-1:0]               quo_col_out,
  output logic [QW-1:0]               quo_row_out
);
  import dcct_pkg::*;

  logic [DIR_W:0]   r2_col;
  logic [DIR_W:0]   r2_row;
  logic [DIR_W:0]   dv;
  logic             ge_col;
  logic             ge_row;
  logic [DIR_W:0]   diff_col;
  logic [DIR_W:0]   diff_row;

  // Double the remainder and try to take the divisor away
  always_comb begin
    dv       = {1'b0, item_in.major};
    r2_col   = {rem_col_in, 1'b0};
    r2_row   = {rem_row_in, 1'b0};
    ge_col   = r2_col >= dv;
    ge_row   = r2_row >= dv;
    diff_col = r2_col - dv;
    diff_row = r2_row - dv;
  end

  // Advance the transaction one step
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
    item_out    <= item_in;
    rem_col_out <= ge_col ? diff_col[DIR_W-1:0] : r2_col[DIR_W-1:0];
    rem_row_out <= ge_row ? diff_row[DIR_W-1:0] : r2_row[DIR_W-1:0];
    quo_col_out <= {quo_col_in[QW-2:0], ge_col};
    quo_row_out <= {quo_row_in[QW-2:0], ge_row};
  end

  // Remainder stays below the divisor after every step
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    valid_out && item_out.hit |->
      rem_col_out < item_out.major && rem_row_out < item_out.major)
    else $error("divider remainder out of range");

endmodule

[rtl/dcct_texel_map.sv]
// Scale half-tile positions by the tile size, clamp to the cross image and form the address.
module dcct_texel_map #(
  parameter int F  = dcct_pkg::COORD_FRAC_BITS_DEF,
  parameter int TW = 11
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              valid_in,
  input  dcct_pkg::item_t                   item_in,
  input  logic [F+1:0]                      quo_col,
  input  logic [F+1:0]                      quo_row,
  input  logic [TW-1:0]                     tile,
  output logic                              done,
  output logic                              hit,
  output logic [dcct_pkg::FACE_W-1:0]       face,
  output logic [dcct_pkg::OUT_COORD_W-1:0]  texel_col,
  output logic [dcct_pkg::OUT_COORD_W-1:0]  texel_row,
  output logic [dcct_pkg::OUT_ADDR_W-1:0]   texel_addr
);
  import dcct_pkg::*;

  localparam int PW = F + 4;
  localparam int MW = PW + TW;
  localparam int VW = MW - F - 1;
  localparam int CW = TW + 2;
  localparam int AW = 2 * CW;

  logic [CW-1:0] tile3;
  logic [CW-1:0] lim_col;
  logic [CW-1:0] lim_row;

  logic          va;
  item_t         item_a;
  logic [PW-1:0] p_col_a;
  logic [PW-1:0] p_row_a;

  logic          vb;
  item_t         item_b;
  logic [MW-1:0] prod_col_b;
  logic [MW-1:0] prod_row_b;

  logic [VW-1:0] v_col;
  logic [VW-1:0] v_row;
  logic          vc;
  item_t         item_c;
  logic [CW-1:0] col_c;
  logic [CW-1:0] row_c;

  logic          vd;
  item_t         item_d;
  logic [CW-1:0] col_d;
  logic [CW-1:0] row_d;
  logic [AW-1:0] rowmul_d;

  // Image limits follow the (static) tile size
  always_comb begin
    tile3   = CW'({tile, 1'b0}) + CW'(tile);
    lim_col = tile3 - CW'(1);
    lim_row = {tile, 2'b00} - CW'(1);
  end

  // Stage a: add the tile offset to the quotient, position in half tiles
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= valid_in;
    end
    item_a  <= item_in;
    p_col_a <= {1'b0, item_in.col_base, {F{1'b0}}} + {2'b00, quo_col};
    p_row_a <= {1'b0, item_in.row_base, {F{1'b0}}} + {2'b00, quo_row};
  end

  // Stage b: scale by the tile size
  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
    item_b     <= item_a;
    prod_col_b <= MW'(p_col_a) * MW'(tile);
    prod_row_b <= MW'(p_row_a) * MW'(tile);
  end

  // Stage c: drop the fraction and the half, clamp; zero everything on a miss
  assign v_col = prod_col_b[MW-1:F+1];
  assign v_row = prod_row_b[MW-1:F+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else begin
      vc <= vb;
    end
    item_c <= item_b;
    if (!item_b.hit) begin
      col_c <= '0;
      row_c <= '0;
    end else begin
      col_c <= (v_col > VW'(lim_col)) ? lim_col : CW'(v_col);
      row_c <= (v_row > VW'(lim_row)) ? lim_row : CW'(v_row);
    end
  end

  // Stage d: row times image width
  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else begin
      vd <= vc;
    end
    item_d   <= item_c;
    col_d    <= col_c;
    row_d    <= row_c;
    rowmul_d <= AW'(row_c) * AW'(tile3);
  end

  // Stage e: linear address and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vd;
    end
    hit        <= item_d.hit;
    face       <= item_d.face;
    texel_col  <= OUT_COORD_W'(col_d);
    texel_row  <= OUT_COORD_W'(row_d);
    texel_addr <= OUT_ADDR_W'(rowmul_d + AW'(col_d));
  end

  // A miss reports face zero and a zero texel
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done |-> hit || (face == '0 && texel_col == '0 && texel_row == '0 &&
                     texel_addr == '0))
    else $error("miss with non-zero result fields");

  // Clamped coordinates never leave the cross image
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    vc |-> col_c <= lim_col && row_c <= lim_row)
    else $error("texel coordinate beyond image edge");

endmodule

[rtl/direction_to_cube_cross_texel.sv]
// Top level of the direction to vertical-cross cube texel lookup.
// Usage: one direction is taken on every cycle that start is high; busy stays low, so a
// transaction is never refused. Each result appears on the result ports for a single
// cycle marked by done, in start order; the receiver has no way to hold it off and must
// take it then. The pipeline is the quotient divider, which forms one fraction bit
// of minor/major per pipeline stage, plus three stages of face selection ahead of it and
// five stages of scaling, clamping and address generation behind it. tile_size may only
// be written while no transaction is in flight; it is clamped to 1..MAX_TILE.
module direction_to_cube_cross_texel #(
  parameter int MAX_TILE        = dcct_pkg::MAX_TILE_DEF,
  parameter int COORD_FRAC_BITS = dcct_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [dcct_pkg::DIR_W-1:0] dir_x,
  input  logic signed [dcct_pkg::DIR_W-1:0] dir_y,
  input  logic signed [dcct_pkg::DIR_W-1:0] dir_z,
  input  logic                              cfg_we,
  input  logic [dcct_pkg::TILE_CFG_W-1:0]   cfg_wdata,
  output logic                              done,
  output logic                              hit,
  output logic [dcct_pkg::FACE_W-1:0]       face,
  output logic [dcct_pkg::OUT_COORD_W-1:0]  texel_col,
  output logic [dcct_pkg::OUT_COORD_W-1:0]  texel_row,
  output logic [dcct_pkg::OUT_ADDR_W-1:0]   texel_addr
);
  import dcct_pkg::*;

  localparam int F  = COORD_FRAC_BITS;
  localparam int QW = F + 2;
  localparam int TW = $clog2(MAX_TILE + 1);

  logic [TILE_CFG_W-1:0] tile_size;
  logic [TW-1:0]         tile_eff;

  logic                  v_d    [0:F];
  item_t                 item_d [0:F];
  logic [DIR_W-1:0]      rc_d   [0:F];
  logic [DIR_W-1:0]      rr_d   [0:F];
  logic [QW-1:0]         qc_d   [0:F];
  logic [QW-1:0]         qr_d   [0:F];

  // The pipeline never stalls
  assign busy = 1'b0;

  // Tile size register
  always_ff @(posedge clk) begin
    if (rst) begin
      tile_size <= TILE_CFG_W'(TILE_RESET);
    end else if (cfg_we) begin
      tile_size <= cfg_wdata;
    end
  end

  // Hold the tile size clamped to 1..MAX_TILE
  always_ff @(posedge clk) begin
    if (tile_size == '0) begin
      tile_eff <= TW'(1);
    end else if (int'(tile_size) > MAX_TILE) begin
      tile_eff <= TW'(MAX_TILE);
    end else begin
      tile_eff <= TW'(tile_size);
    end
  end

  dcct_face_sel #(
    .QW (QW)
  ) u_face_sel (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .dir_x     (dir_x),
    .dir_y     (dir_y),
    .dir_z     (dir_z),
    .valid_out (v_d[0]),
    .item_out  (item_d[0]),
    .rem_col   (rc_d[0]),
    .rem_row   (rr_d[0]),
    .quo_col   (qc_d[0]),
    .quo_row   (qr_d[0])
  );

  // Fraction bits of minor/major, one per stage
  for (genvar k = 0; k < F; k++) begin : g_div
    dcct_div_step #(
      .QW (QW)
    ) u_div_step (
      .clk         (clk),
      .rst         (rst),
      .valid_in    (v_d[k]),
      .item_in     (item_d[k]),
      .rem_col_in  (rc_d[k]),
      .rem_row_in  (rr_d[k]),
      .quo_col_in  (qc_d[k]),
      .quo_row_in  (qr_d[k]),
      .valid_out   (v_d[k+1]),
      .item_out    (item_d[k+1]),
      .rem_col_out (rc_d[k+1]),
      .rem_row_out (rr_d[k+1]),
      .quo_col_out (qc_d[k+1]),
      .quo_row_out (qr_d[k+1])
    );
  end

  dcct_texel_map #(
    .F  (F),
    .TW (TW)
  ) u_texel_map (
    .clk        (clk),
    .rst        (rst),
    .valid_in   (v_d[F]),
    .item_in    (item_d[F]),
    .quo_col    (qc_d[F]),
    .quo_row    (qr_d[F]),
    .tile       (tile_eff),
    .done       (done),
    .hit        (hit),
    .face       (face),
    .texel_col  (texel_col),
    .texel_row  (texel_row),
    .texel_addr (texel_addr)
  );

endmodule

[tb/direction_to_cube_cross_texel_tb.sv]
// Self-checking testbench for the direction to cube cross texel lookup.
module direction_to_cube_cross_texel_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dcct_pkg::*;

  localparam int LATENCY     = COORD_FRAC_BITS_DEF + 8;
  localparam int FRAC        = COORD_FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_PRINTS  = 40;

  // Axis and face codes in table order
  localparam int AX_X = 0;
  localparam int AX_Y = 1;
  localparam int AX_Z = 2;

  typedef enum int {
    FACE_POS_Y = 0,
    FACE_POS_X = 1,
    FACE_POS_Z = 2,
    FACE_NEG_Y = 3,
    FACE_NEG_X = 4,
    FACE_NEG_Z = 5
  } face_e;

  // Per-face geometry: sign, axes, offsets in half tiles and slope signs
  localparam int SIGN_TAB [6]   = '{1, 1, 1, -1, -1, -1};
  localparam int MAJOR_TAB [6]  = '{AX_Y, AX_X, AX_Z, AX_Y, AX_X, AX_Z};
  localparam int COLAX_TAB [6]  = '{AX_X, AX_Z, AX_X, AX_X, AX_Z, AX_X};
  localparam int ROWAX_TAB [6]  = '{AX_Z, AX_Y, AX_Y, AX_Z, AX_Y, AX_Y};
  localparam int COLOFF_TAB [6] = '{3, 5, 3, 3, 1, 3};
  localparam int COLSLP_TAB [6] = '{1, 1, 1, -1, 1, -1};
  localparam int ROWOFF_TAB [6] = '{5, 3, 7, 1, 3, 3};
  localparam int ROWSLP_TAB [6] = '{1, 1, -1, 1, -1, -1};

  typedef struct {
    logic                   hit;
    logic [FACE_W-1:0]      face;
    logic [OUT_COORD_W-1:0] col;
    logic [OUT_COORD_W-1:0] row;
    logic [OUT_ADDR_W-1:0]  addr;
  } texel_result_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic signed [DIR_W-1:0] dir_x = '0;
  logic signed [DIR_W-1:0] dir_y = '0;
  logic signed [DIR_W-1:0] dir_z = '0;
  logic                   cfg_we = 1'b0;
  logic [TILE_CFG_W-1:0]  cfg_wdata = '0;
  logic                   done;
  logic                   hit;
  logic [FACE_W-1:0]      face;
  logic [OUT_COORD_W-1:0] texel_col;
  logic [OUT_COORD_W-1:0] texel_row;
  logic [OUT_ADDR_W-1:0]  texel_addr;

  texel_result_t         pending_texels [$];
  logic [TILE_CFG_W-1:0] tile_reg = TILE_RESET[TILE_CFG_W-1:0];
  bit                    no_idle = 1'b0;
  int                    mismatches = 0;
  int                    items_sent = 0;
  int                    results_seen = 0;
  int                    hits_seen = 0;
  int                    tile_writes = 0;
  int                    cycles = 0;

  direction_to_cube_cross_texel uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .dir_x      (dir_x),
    .dir_y      (dir_y),
    .dir_z      (dir_z),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .done       (done),
    .hit        (hit),
    .face       (face),
    .texel_col  (texel_col),
    .texel_row  (texel_row),
    .texel_addr (texel_addr)
  );

  // Free-running clock, 12 ns period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               pending_texels.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Position along one tile axis, in pixels, clamped to the image edge
  function automatic longint unsigned texel_coord(input int off2, input int slope,
                                                  input int minor, input int maj,
                                                  input longint unsigned tile,
                                                  input longint unsigned limit);
    longint          u;
    longint unsigned uu;
    longint unsigned p;
    longint unsigned v;
    u  = longint'(off2) * maj + longint'(slope) * minor;
    uu = (u < 0) ? 64'd0 : longint'(u);
    p  = (uu << FRAC) / longint'(maj);
    v  = (p * tile) >> (FRAC + 1);
    return (v > limit) ? limit : v;
  endfunction

  // Select the face and work out the texel for one direction
  function automatic texel_result_t predict_texel(input logic signed [DIR_W-1:0] x,
                                                  input logic signed [DIR_W-1:0] y,
                                                  input logic signed [DIR_W-1:0] z,
                                                  input logic [TILE_CFG_W-1:0] treg);
    texel_result_t   r;
    int              d [3];
    int              sel;
    int              maj;
    int              ca;
    int              rb;
    longint unsigned tile;
    longint unsigned col;
    longint unsigned row;
    longint unsigned addr;
    d[AX_X] = x;
    d[AX_Y] = y;
    d[AX_Z] = z;
    sel  = -1;
    col  = 0;
    row  = 0;
    addr = 0;
    tile = treg;
    if (tile == 0) tile = 1;
    if (tile > MAX_TILE_DEF) tile = MAX_TILE_DEF;
    // Later faces override earlier ones on a tie
    for (int i = 0; i < 6; i++) begin
      maj = SIGN_TAB[i] * d[MAJOR_TAB[i]];
      ca  = d[COLAX_TAB[i]] < 0 ? -d[COLAX_TAB[i]] : d[COLAX_TAB[i]];
      rb  = d[ROWAX_TAB[i]] < 0 ? -d[ROWAX_TAB[i]] : d[ROWAX_TAB[i]];
      if (maj > 0 && maj >= ca && maj >= rb) sel = i;
    end
    if (sel >= 0) begin
      maj  = SIGN_TAB[sel] * d[MAJOR_TAB[sel]];
      ca   = SIGN_TAB[sel] * d[COLAX_TAB[sel]];
      rb   = SIGN_TAB[sel] * d[ROWAX_TAB[sel]];
      col  = texel_coord(COLOFF_TAB[sel], COLSLP_TAB[sel], ca, maj, tile, 3 * tile - 1);
      row  = texel_coord(ROWOFF_TAB[sel], ROWSLP_TAB[sel], rb, maj, tile, 4 * tile - 1);
      addr = row * 3 * tile + col;
    end
    r.hit  = (sel >= 0);
    r.face = (sel >= 0) ? sel[FACE_W-1:0] : '0;
    r.col  = col[OUT_COORD_W-1:0];
    r.row  = row[OUT_COORD_W-1:0];
    r.addr = addr[OUT_ADDR_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("[%0t] MISMATCH %s: got %0d, expected %0d (result %0d)", $realtime, what,
               got, want, results_seen);
  endtask

  // Compare each strobed result with the oldest prediction
  always @(posedge clk) begin
    texel_result_t want;
    if (!rst && done) begin
      results_seen++;
      if (hit) hits_seen++;
      if (pending_texels.size() == 0) begin
        report_mismatch("unexpected result, queue empty", 1, 0);
      end else begin
        want = pending_texels.pop_front();
        if (hit !== want.hit) report_mismatch("hit", hit, want.hit);
        if (face !== want.face) report_mismatch("face", face, want.face);
        if (texel_col !== want.col) report_mismatch("texel_col", texel_col, want.col);
        if (texel_row !== want.row) report_mismatch("texel_row", texel_row, want.row);
        if (texel_addr !== want.addr) report_mismatch("texel_addr", texel_addr, want.addr);
      end
    end
  end

  // Present one direction after a random gap (none when no_idle is set) and hold until the transaction is taken
  task automatic send_direction(input logic signed [DIR_W-1:0] x,
                                input logic signed [DIR_W-1:0] y,
                                input logic signed [DIR_W-1:0] z);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    dir_x <= x;
    dir_y <= y;
    dir_z <= z;
    do @(posedge clk); while (busy);
    pending_texels.insert(pending_texels.size(), predict_texel(x, y, z, tile_reg));
    items_sent++;
  endtask

  // Drop start and let every transaction in flight complete
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_texels.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_tile(input logic [TILE_CFG_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    tile_reg = value;
    tile_writes++;
  endtask

  // Draw a signed component of magnitude up to mag, never past the 16-bit range
  function automatic logic signed [DIR_W-1:0] minor_upto(input int mag);
    int m;
    m = $urandom_range(0, mag);
    if (m == 32768 || $urandom_range(0, 1)) m = -m;
    return m[DIR_W-1:0];
  endfunction

  function automatic logic signed [DIR_W-1:0] pick_extreme();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh8001;
      2: return -16'sd1;
      3: return 16'sd0;
      4: return 16'sd1;
      default: return 16'sh7fff;
    endcase
  endfunction

  // Half the directions aimed at a chosen face, the rest raw noise, ties, tiny vectors and range extremes
  task automatic random_direction(output logic signed [DIR_W-1:0] x,
                                  output logic signed [DIR_W-1:0] y,
                                  output logic signed [DIR_W-1:0] z);
    logic signed [DIR_W-1:0] d [3];
    int kind;
    int ax;
    int mag;
    bit neg;
    kind = $urandom_range(0, 99);
    if (kind < 50) begin
      ax  = $urandom_range(0, 2);
      neg = 1'($urandom_range(0, 1));
      mag = neg ? $urandom_range(1, 32768) : $urandom_range(1, 32767);
      if ($urandom_range(0, 3) == 0) mag = $urandom_range(1, 64);
      for (int i = 0; i < 3; i++) d[i] = minor_upto(mag);
      d[ax] = DIR_W'(neg ? -mag : mag);
    end else if (kind < 70) begin
      for (int i = 0; i < 3; i++) d[i] = DIR_W'($urandom_range(0, 65535));
    end else if (kind < 80) begin
      mag = $urandom_range(1, 32767);
      for (int i = 0; i < 3; i++) d[i] = DIR_W'($urandom_range(0, 1) ? -mag : mag);
      if ($urandom_range(0, 1)) d[$urandom_range(0, 2)] = minor_upto(mag);
    end else if (kind < 90) begin
      for (int i = 0; i < 3; i++) d[i] = DIR_W'($urandom_range(0, 6) - 3);
    end else begin
      for (int i = 0; i < 3; i++) d[i] = pick_extreme();
    end
    x = d[AX_X];
    y = d[AX_Y];
    z = d[AX_Z];
  endtask

  task automatic send_random(input int count);
    logic signed [DIR_W-1:0] x;
    logic signed [DIR_W-1:0] y;
    logic signed [DIR_W-1:0] z;
    for (int n = 0; n < count; n++) begin
      // Mix stretches of random gaps with back-to-back streaming, chosen at random every 50 directions
      if (n % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      random_direction(x, y, z);
      send_direction(x, y, z);
    end
    no_idle = 1'b0;
  endtask

  // Axis-aligned directions, ties between faces, the zero vector and range extremes
  task automatic test_directed_faces();
    send_direction(16'sd0, 16'sd0, 16'sd0);
    send_direction(16'sd0, 16'sh7fff, 16'sd0);
    send_direction(16'sh7fff, 16'sd0, 16'sd0);
    send_direction(16'sd0, 16'sd0, 16'sh7fff);
    send_direction(16'sd0, 16'sh8000, 16'sd0);
    send_direction(16'sh8000, 16'sd0, 16'sd0);
    send_direction(16'sd0, 16'sd0, 16'sh8000);
    send_direction(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_direction(16'sh8000, 16'sh8000, 16'sh8000);
    send_direction(16'sh7fff, 16'sh8000, 16'sd0);
    send_direction(16'sh8001, 16'sh7fff, 16'sh8001);
    send_direction(16'sd1, 16'sd0, 16'sd0);
    send_direction(16'sd0, -16'sd1, 16'sd0);
    send_direction(16'sd1, 16'sd1, -16'sd1);
    send_direction(16'sh7fff, 16'sh8001, 16'sh7fff);
    send_direction(16'sh8001, 16'sh7fff, 16'sh7fff);
    send_direction(16'sh7fff, 16'sh7fff, 16'sh8001);
    send_direction(16'sh8000, 16'sh7fff, 16'sh7fff);
    send_direction(-16'sd1, 16'sd1, 16'sd1);
    send_direction(16'sh4000, 16'sh7fff, 16'sh8001);
    wait_idle();
  endtask

  // Zero, smallest, largest and saturating tile sizes
  task automatic test_tile_extremes();
    logic [TILE_CFG_W-1:0] sizes [5] = '{11'd0, 11'd1, 11'd1024, 11'd2047, 11'd1025};
    foreach (sizes[i]) begin
      write_tile(sizes[i]);
      send_direction(16'sh8000, 16'sh8000, 16'sh8000);
      send_direction(16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_random(70);
    end
    wait_idle();
  endtask

  task automatic test_random_tiles();
    for (int k = 0; k < 6; k++) begin
      write_tile((k == 0) ? 11'd3 : 11'($urandom_range(1, 1024)));
      send_random(200);
    end
    wait_idle();
  endtask

  // Stream with no gaps at a single size, after returning to the reset value
  task automatic test_back_to_back();
    logic signed [DIR_W-1:0] x;
    logic signed [DIR_W-1:0] y;
    logic signed [DIR_W-1:0] z;
    write_tile(11'd256);
    no_idle = 1'b1;
    for (int n = 0; n < 330; n++) begin
      random_direction(x, y, z);
      send_direction(x, y, z);
    end
    no_idle = 1'b0;
    wait_idle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_faces();
    test_tile_extremes();
    test_random_tiles();
    test_back_to_back();
    wait_idle();
    $display("Covered %0d directions over %0d tile size writes plus the reset size;",
             items_sent, tile_writes);
    $display("checked %0d results, %0d of them face hits, %0d mismatches.",
             results_seen, hits_seen, mismatches);
    if (mismatches == 0 && pending_texels.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/dcct_pkg.sv
rtl/dcct_face_sel.sv
rtl/dcct_div_step.sv
rtl/dcct_texel_map.sv
rtl/direction_to_cube_cross_texel.sv
tb/direction_to_cube_cross_texel_tb.sv
